@@ hdl/spq_pkg.sv @@
// Shared types and constants for the sorted-set priority queue.
// Used by spq_ram's users and by the top level; depends on nothing.
package spq_pkg;

   localparam int SPQ_DEPTH = 64;
   localparam int KEY_BITS  = 31;
   localparam int TAG_BITS  = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_BITS-1:0] out_key;
      logic [TAG_BITS-1:0] out_tag;
      logic                now_empty;
   } rsp_type;

   // One stored entry as it sits in the entry memory.
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

endpackage

@@ hdl/sorted_set_priority_queue.sv @@
// Sorted-set priority queue: sequencer, shared compare/address unit, result register.
// Depends on spq_pkg and spq_ram (entry memory).
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | req_data (req_type: op, key, tag)
//   rsp     | out | rsp_valid/rsp_ready  | rsp_data (rsp_type: status, out_key, out_tag, now_empty)
//
// Entries live in a circular buffer in one RAM, smallest key at the head pointer.
// A remove reads and returns the head entry; an empty remove answers without a RAM access.
// An insert binary-searches (one RAM read and compare per probe), then
// moves each entry above the slot up by one (a read, then a write, per entry), then
// writes the new entry. The single RAM port pair makes these steps run one after another.
// Synchronous reset empties the store at once; memory contents are not cleared.
// A finished result waits in the output register while the next request is taken.
module sorted_set_priority_queue import spq_pkg::*; #(
   parameter int DEPTH = SPQ_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH,
      S_CMP,
      S_SHIFT,
      S_MOVE,
      S_REM,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CNT_W:0]      mid_sum;
   logic [CNT_W-1:0]    log_idx;
   logic [IDX_W:0]      phys_sum;
   logic [IDX_W-1:0]    phys_addr;
   logic                ram_we;
   logic                ram_re;
   entry_type           ram_wdata;
   entry_type           ram_rdata;

   spq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (phys_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (phys_addr),
      .rd_data (ram_rdata)
   );

   assign mid_sum = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;

   // Logical position in sorted order that this cycle's RAM access targets.
   always_comb begin
      case (state_ff)
         S_SRCH:  log_idx = mid_sum[CNT_W-1:0];
         S_SHIFT: log_idx = (idx_ff > lo_ff) ? (idx_ff - CNT_W'(1)) : lo_ff;
         S_MOVE:  log_idx = idx_ff;
         default: log_idx = '0;
      endcase
   end

   // Shared address unit: logical position to circular buffer slot.
   assign phys_sum  = {1'b0, head_ff} + (IDX_W+1)'(log_idx[IDX_W-1:0]);
   assign phys_addr = (phys_sum >= (IDX_W+1)'(DEPTH)) ?
                      IDX_W'(phys_sum - (IDX_W+1)'(DEPTH)) : phys_sum[IDX_W-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      tag_in       = tag_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wdata    = '{key: key_ff, tag: tag_ff};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in = req_data.key;
               tag_in = req_data.tag;
               if (req_data.op == OP_REMOVE) begin
                  if (count_ff == '0) begin
                     res_in   = '{status: ST_EMPTY, out_key: '0, out_tag: '0,
                                  now_empty: 1'b1};
                     state_in = S_FINISH;
                  end else begin
                     // Head entry is the smallest key.
                     ram_re   = 1'b1;
                     state_in = S_REM;
                  end
               end else begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[IDX_W-1:0];
               ram_re   = 1'b1;
               state_in = S_CMP;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               res_in   = '{status: ST_FULL, out_key: '0, out_tag: '0,
                            now_empty: 1'b0};
               state_in = S_FINISH;
            end else begin
               idx_in   = count_ff;
               state_in = S_SHIFT;
            end
         end
         S_CMP: begin
            if (ram_rdata.key == key_ff) begin
               res_in   = '{status: ST_DUPLICATE, out_key: '0, out_tag: '0,
                            now_empty: 1'b0};
               state_in = S_FINISH;
            end else begin
               if (ram_rdata.key < key_ff) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_in = CNT_W'(mid_ff);
               end
               state_in = S_SRCH;
            end
         end
         S_SHIFT: begin
            if (idx_ff > lo_ff) begin
               ram_re   = 1'b1;
               state_in = S_MOVE;
            end else begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               res_in   = '{status: ST_INSERTED, out_key: '0, out_tag: '0,
                            now_empty: 1'b0};
               state_in = S_FINISH;
            end
         end
         S_MOVE: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_ff - CNT_W'(1);
            state_in  = S_SHIFT;
         end
         S_REM: begin
            res_in   = '{status: ST_REMOVED, out_key: ram_rdata.key,
                         out_tag: ram_rdata.tag, now_empty: (count_ff == CNT_W'(1))};
            count_in = count_ff - CNT_W'(1);
            head_in  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
      key_ff <= key_in;
      tag_ff <= tag_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH |-> lo_ff <= hi_ff && hi_ff <= count_ff)
      else $error("search window inverted");

   a_move_above_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE |-> idx_ff > lo_ff && idx_ff < CNT_W'(DEPTH))
      else $error("entry move below insertion slot");

   // The next request may already be under way while this result waits.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_EMPTY |-> rsp_ff.now_empty)
      else $error("empty result without empty flag");

   a_remove_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REM |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not decrement count");

endmodule

@@ hdl/spq_ram.sv @@
// Generic RAM with one write port and one read port, registered read data.
// Standalone; no package dependencies.
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
